@@ design/tpdp_pkg.sv @@
// Package for the ternary packed dot product engine.
// Holds the field widths, store geometry, mode codes and the base-3 trit decoder.
// Used by design/ternary_packed_dot_product.sv; depends on nothing else.
package tpdp_pkg;

  localparam int TRITS          = 5;
  localparam int ACT_W          = 8;
  localparam int GROUP_W        = 10;
  localparam int CODE_W         = 8;
  localparam int SUM_W          = 21;
  localparam int MAX_GROUPS     = 1024;
  localparam int GIDX_W         = $clog2(MAX_GROUPS);
  localparam int ENTRY_W        = TRITS * ACT_W;
  localparam int TRIT_VEC_W     = 2 * TRITS;
  // A group's weighted sum stays within five times one activation.
  localparam int GSUM_W         = ACT_W + 3;
  localparam logic [CODE_W-1:0] MAX_VALID_CODE = 8'd242;

  // Item kinds on the input channel.
  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_ACC  = 1'b1
  } mode_t;

  // Raw digit codes: 0 means weight -1, 1 means 0, 2 means +1.
  localparam logic [1:0] TRIT_NEG  = 2'd0;
  localparam logic [1:0] TRIT_ZERO = 2'd1;
  localparam logic [1:0] TRIT_POS  = 2'd2;

  // Splits a packed byte into five base-3 digits, least significant first.
  // The quotients by 3, 9 and 27 come side by side from reciprocal multiplies
  // (171, 57 and 19 over 512), exact for every 8-bit value; the quotient by 81
  // comes from compares. Each digit is one quotient minus three times the next.
  // Bytes above the last valid code give digits that the datapath discards.
  function automatic logic [TRIT_VEC_W-1:0] decode_trits(input logic [CODE_W-1:0] code);
    logic [15:0]           prod3;
    logic [15:0]           prod9;
    logic [15:0]           prod27;
    logic [CODE_W-1:0]     quo [TRITS];
    logic [CODE_W-1:0]     rem;
    logic [TRIT_VEC_W-1:0] digits;
    prod3  = {8'd0, code} * 16'd171;
    prod9  = {8'd0, code} * 16'd57;
    prod27 = {8'd0, code} * 16'd19;
    quo[0] = code;
    quo[1] = {1'b0, prod3[15:9]};
    quo[2] = {3'd0, prod9[13:9]};
    quo[3] = {4'd0, prod27[12:9]};
    if (code >= 8'd243) begin
      quo[4] = 8'd3;
    end else if (code >= 8'd162) begin
      quo[4] = 8'd2;
    end else if (code >= 8'd81) begin
      quo[4] = 8'd1;
    end else begin
      quo[4] = 8'd0;
    end
    digits = '0;
    for (int i = 0; i < TRITS - 1; i++) begin
      rem = quo[i] - ({quo[i+1][6:0], 1'b0} + quo[i+1]);
      digits[2*i +: 2] = rem[1:0];
    end
    digits[2*(TRITS-1) +: 2] = quo[TRITS-1][1:0];
    return digits;
  endfunction

endpackage

@@ design/ternary_packed_dot_product.sv @@
// Ternary-weight row engine with base-3 packed weight bytes and an activation store.
// Depends on design/tpdp_pkg.sv for widths, mode codes and the trit decoder.
// A row-closing weight beat passes through stage one and then the result register,
// and waits longer only while an earlier result still waits in the result register.
// Throughput: one beat per cycle while no closing beat waits for the result register;
// the store's single read port and the one-beat accumulate stage set that figure.
// Reset clears the pipeline valid bits, the accumulator and the row's bad-code flag;
// the activation store is not cleared and holds no defined value until written.
module ternary_packed_dot_product
  import tpdp_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       mode,
  input  logic [GROUP_W-1:0]         group,
  input  logic signed [ACT_W-1:0]    act0,
  input  logic signed [ACT_W-1:0]    act1,
  input  logic signed [ACT_W-1:0]    act2,
  input  logic signed [ACT_W-1:0]    act3,
  input  logic signed [ACT_W-1:0]    act4,
  input  logic [CODE_W-1:0]          weight_code,
  input  logic                       row_last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SUM_W-1:0]    row_sum,
  output logic                       bad_code
);

  logic [ENTRY_W-1:0] act_mem [MAX_GROUPS];

  // Stage one: store read data and decoded digits of one weight beat.
  logic                  s1_valid;
  logic                  s1_last;
  logic                  s1_bad;
  logic [TRIT_VEC_W-1:0] s1_trits;
  logic [ENTRY_W-1:0]    s1_acts;

  // Row state.
  logic signed [SUM_W-1:0] acc;
  logic                    bad_seen;

  logic                    in_fire;
  logic                    s1_go;
  logic [GIDX_W-1:0]       gidx;
  logic                    code_bad;
  logic signed [GSUM_W-1:0] group_sum;
  logic signed [SUM_W-1:0] acc_next;
  logic                    bad_next;

  assign gidx     = group[GIDX_W-1:0];
  assign code_bad = (weight_code > MAX_VALID_CODE);

  // A closing beat may leave stage one only when the result register is free.
  assign s1_go    = s1_valid && (!s1_last || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;
  assign in_fire  = in_valid && in_ready;

  // Activation store: load beats write, weight beats read one entry.
  always_ff @(posedge clk) begin
    if (in_fire && mode == MODE_LOAD) begin
      act_mem[gidx] <= {act4, act3, act2, act1, act0};
    end
    if (in_fire && mode == MODE_ACC) begin
      s1_acts <= act_mem[gidx];
    end
  end

  // Stage one payload: decode the digits while the store is read.
  always_ff @(posedge clk) begin
    if (in_fire && mode == MODE_ACC) begin
      s1_trits <= decode_trits(weight_code);
      s1_bad   <= code_bad;
      s1_last  <= row_last;
    end
  end

  // Stage one occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= (mode == MODE_ACC);
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  // Weighted sum of the group; an invalid byte adds nothing.
  always_comb begin
    logic signed [GSUM_W-1:0] a;
    group_sum = '0;
    for (int i = 0; i < TRITS; i++) begin
      a = GSUM_W'(signed'(s1_acts[ACT_W*i +: ACT_W]));
      case (s1_trits[2*i +: 2])
        TRIT_NEG: group_sum = group_sum - a;
        TRIT_POS: group_sum = group_sum + a;
        default:  group_sum = group_sum;
      endcase
    end
    if (s1_bad) begin
      group_sum = '0;
    end
  end

  assign acc_next = acc + SUM_W'(group_sum);
  assign bad_next = bad_seen | s1_bad;

  // Row accumulation; the closing beat hands the total over and clears the row.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      bad_seen <= 1'b0;
    end else if (s1_go) begin
      if (s1_last) begin
        acc      <= '0;
        bad_seen <= 1'b0;
      end else begin
        acc      <= acc_next;
        bad_seen <= bad_next;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last) begin
      row_sum  <= acc_next;
      bad_code <= bad_next;
    end
  end

endmodule

@@ sim/ternary_packed_dot_product_tb.sv @@
// Self-checking testbench for the ternary packed dot product engine: activation loads,
// packed base-3 weight beats, row sums and the bad-code flag, under random idling.
// Depends on design/tpdp_pkg.sv and design/ternary_packed_dot_product.sv.
`timescale 1ns / 100ps

module ternary_packed_dot_product_tb;
  import tpdp_pkg::*;

  // One expected row result.
  typedef struct packed {
    logic signed [SUM_W-1:0] row_total;
    logic                    bad;
  } row_result_t;

  // One input beat as the driver sees it.
  typedef struct {
    mode_t                          kind;
    logic [GROUP_W-1:0]             grp;
    logic [TRITS-1:0][ACT_W-1:0]    acts;
    logic [CODE_W-1:0]              code;
    logic                           last;
  } tpdp_beat_t;

  // Predicts row sums from accepted beats and checks the sums that come out.
  class dot_product_scoreboard;
    logic signed [ACT_W-1:0] act_mem [MAX_GROUPS][TRITS];
    logic [SUM_W-1:0]        acc;
    logic                    bad_seen;
    row_result_t             expected_rows[$];
    int unsigned             errors;
    int unsigned             rows_checked;
    int unsigned             beats_noted;

    function new();
      acc          = '0;
      bad_seen     = 1'b0;
      errors       = 0;
      rows_checked = 0;
      beats_noted  = 0;
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= 10) begin
        $display("MISMATCH at %0t: %s", $realtime, msg);
      end
    endfunction

    // Updates the predicted state for one accepted beat.
    function void note_beat(tpdp_beat_t b);
      int          contrib;
      int          rest;
      int          digit;
      row_result_t r;
      beats_noted++;
      if (b.kind == MODE_LOAD) begin
        for (int i = 0; i < TRITS; i++) begin
          act_mem[b.grp][i] = b.acts[i];
        end
        return;
      end
      // A byte beyond the last valid code only raises the flag.
      if (b.code > MAX_VALID_CODE) begin
        bad_seen = 1'b1;
      end else begin
        contrib = 0;
        rest    = b.code;
        for (int i = 0; i < TRITS; i++) begin
          digit = rest % 3;
          rest  = rest / 3;
          if (digit == TRIT_NEG) begin
            contrib -= int'(act_mem[b.grp][i]);
          end else if (digit == TRIT_POS) begin
            contrib += int'(act_mem[b.grp][i]);
          end
        end
        acc = acc + SUM_W'(contrib);
      end
      // The closing beat of a row emits the sum and clears the row state.
      if (b.last) begin
        r.row_total = acc;
        r.bad       = bad_seen;
        expected_rows.push_back(r);
        acc      = '0;
        bad_seen = 1'b0;
      end
    endfunction

    // Compares one accepted result with the oldest expectation.
    function void check_row(logic signed [SUM_W-1:0] got_total, logic got_bad);
      row_result_t want;
      if (expected_rows.size() == 0) begin
        note_error($sformatf("unexpected row result: sum %0d bad %0b",
                             got_total, got_bad));
        return;
      end
      want = expected_rows.pop_front();
      rows_checked++;
      if (got_total !== want.row_total) begin
        note_error($sformatf("row %0d sum: expected %0d, got %0d", rows_checked,
                             $signed(want.row_total), got_total));
      end
      if (got_bad !== want.bad) begin
        note_error($sformatf("row %0d bad_code: expected %0b, got %0b", rows_checked,
                             want.bad, got_bad));
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid;
  logic                     in_ready;
  logic                     mode;
  logic [GROUP_W-1:0]       group;
  logic signed [ACT_W-1:0]  act0;
  logic signed [ACT_W-1:0]  act1;
  logic signed [ACT_W-1:0]  act2;
  logic signed [ACT_W-1:0]  act3;
  logic signed [ACT_W-1:0]  act4;
  logic [CODE_W-1:0]        weight_code;
  logic                     row_last;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [SUM_W-1:0]  row_sum;
  logic                     bad_code;

  dot_product_scoreboard sb = new();

  // Stimulus shaping shared between the two sides.
  bit                       burst_on;
  bit                       sender_fast;
  bit                       written [MAX_GROUPS];
  logic [GROUP_W-1:0]       written_groups[$];
  int unsigned              beats_sent;

  ternary_packed_dot_product dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .group       (group),
    .act0        (act0),
    .act1        (act1),
    .act2        (act2),
    .act3        (act3),
    .act4        (act4),
    .weight_code (weight_code),
    .row_last    (row_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .row_sum     (row_sum),
    .bad_code    (bad_code)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic tpdp_beat_t load_beat(logic [GROUP_W-1:0] grp,
                                           logic [TRITS-1:0][ACT_W-1:0] acts);
    tpdp_beat_t b;
    b.kind = MODE_LOAD;
    b.grp  = grp;
    b.acts = acts;
    b.code = CODE_W'($urandom);
    b.last = 1'($urandom);
    return b;
  endfunction

  function automatic tpdp_beat_t acc_beat(logic [GROUP_W-1:0] grp,
                                          logic [CODE_W-1:0] code, logic last);
    tpdp_beat_t b;
    b.kind = MODE_ACC;
    b.grp  = grp;
    for (int i = 0; i < TRITS; i++) begin
      b.acts[i] = ACT_W'($urandom);
    end
    b.code = code;
    b.last = last;
    return b;
  endfunction

  // Mostly weight beats on groups already loaded, with some loads, fresh or repeated, and bad bytes.
  function automatic tpdp_beat_t random_beat();
    logic [TRITS-1:0][ACT_W-1:0] acts;
    logic [GROUP_W-1:0]          grp;
    logic [CODE_W-1:0]           code;
    for (int i = 0; i < TRITS; i++) begin
      acts[i] = ACT_W'($urandom);
    end
    if (written_groups.size() == 0 || $urandom_range(0, 3) == 0) begin
      if ($urandom_range(0, 1) == 0 && written_groups.size() != 0) begin
        grp = written_groups[$urandom_range(0, written_groups.size() - 1)];
      end else begin
        grp = GROUP_W'($urandom);
      end
      return load_beat(grp, acts);
    end
    grp = written_groups[$urandom_range(0, written_groups.size() - 1)];
    if ($urandom_range(0, 9) == 0) begin
      code = CODE_W'($urandom_range(MAX_VALID_CODE + 1, 255));
    end else begin
      code = CODE_W'($urandom_range(0, MAX_VALID_CODE));
    end
    return acc_beat(grp, code, $urandom_range(0, 3) == 0);
  endfunction

  // Offers one beat after a random gap and returns at the edge that accepts it.
  task automatic send_beat(input tpdp_beat_t b);
    int gap;
    if ($urandom_range(0, 39) == 0) begin
      sender_fast = !sender_fast;
    end
    gap = (sender_fast || burst_on) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= b.kind;
    group       <= b.grp;
    act0        <= b.acts[0];
    act1        <= b.acts[1];
    act2        <= b.acts[2];
    act3        <= b.acts[3];
    act4        <= b.acts[4];
    weight_code <= b.code;
    row_last    <= b.last;
    do @(posedge clk); while (!in_ready);
    sb.note_beat(b);
    beats_sent++;
    if (b.kind == MODE_LOAD && !written[b.grp]) begin
      written[b.grp] = 1'b1;
      written_groups.push_back(b.grp);
    end
  endtask

  // Result side: random stalls, and one long hold-off once results are flowing.
  initial begin : result_sink
    int stall;
    bit fast;
    bit held;
    out_ready = 1'b0;
    burst_on  = 1'b0;
    fast = 1'b0;
    held = 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (!held && sb.rows_checked >= 20) begin
        held     = 1'b1;
        burst_on = 1'b1;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        burst_on = 1'b0;
      end else begin
        if ($urandom_range(0, 29) == 0) begin
          fast = !fast;
        end
        stall = fast ? 0 : $urandom_range(0, 16);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_row(row_sum, bad_code);
    end
  end

  // Input side: directed beats, then random traffic.
  initial begin : stimulus
    in_valid    = 1'b0;
    mode        = MODE_LOAD;
    group       = '0;
    act0        = '0;
    act1        = '0;
    act2        = '0;
    act3        = '0;
    act4        = '0;
    weight_code = '0;
    row_last    = 1'b0;
    sender_fast = 1'b0;
    beats_sent  = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Extreme activations; loads also carry a stray code and row flag to be ignored.
    send_beat(load_beat(10'd0,    {8'sd127, 8'sd127, 8'sd127, 8'sd127, 8'sd127}));
    send_beat(load_beat(10'd1023, {-8'sd128, -8'sd128, -8'sd128, -8'sd128, -8'sd128}));
    send_beat(load_beat(10'd1,    {-8'sd1, 8'sd1, 8'sd0, -8'sd128, 8'sd127}));
    send_beat(load_beat(10'd682,  {8'sh55, 8'shAA, 8'sh0F, 8'shF0, 8'sh5A}));
    // All weights -1, then all +1 across two groups.
    send_beat(acc_beat(10'd0, 8'd0, 1'b1));
    send_beat(acc_beat(10'd0, MAX_VALID_CODE, 1'b0));
    send_beat(acc_beat(10'd1023, MAX_VALID_CODE, 1'b1));
    // All weights zero, and mixed digit patterns.
    send_beat(acc_beat(10'd1, 8'd121, 1'b1));
    send_beat(acc_beat(10'd1, 8'd5, 1'b0));
    send_beat(acc_beat(10'd682, 8'd200, 1'b1));
    // Invalid bytes inside a row and a row of nothing but an invalid byte.
    send_beat(acc_beat(10'd1, MAX_VALID_CODE + 8'd1, 1'b0));
    send_beat(acc_beat(10'd0, 8'd17, 1'b0));
    send_beat(acc_beat(10'd0, 8'd255, 1'b1));
    send_beat(acc_beat(10'd1023, 8'd255, 1'b1));
    // An activation reload in the middle of a row.
    send_beat(acc_beat(10'd682, 8'd100, 1'b0));
    send_beat(load_beat(10'd682, {8'sd3, -8'sd7, 8'sd64, -8'sd100, 8'sd9}));
    send_beat(acc_beat(10'd682, 8'd100, 1'b1));

    for (int n = 0; n < 430; n++) begin
      send_beat(random_beat());
    end
    // Close whatever row is still open.
    send_beat(acc_beat(written_groups[0], 8'd121, 1'b1));
    in_valid <= 1'b0;

    // Drain outstanding rows, then allow for the pipeline depth.
    while (sb.expected_rows.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Run covered %0d input beats and %0d checked row sums, including bad",
             beats_sent, sb.rows_checked);
    $display("weight bytes, mid-row activation reloads and a long output hold-off.");
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches in total", sb.errors);
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hang guard, several times the slowest legal run.
  initial begin : watchdog
    #3_000_000;
    $display("Timeout: results stopped arriving, %0d rows still expected",
             sb.expected_rows.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
